// ----- rtl/core/assert_macros.svh -----
// Assertion macros shared by the RTL of the UTF-8 stream decoder.
// No dependencies; included by files that carry concurrent assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion that is switched off while the synchronous reset is low.
`define U8D_ASSERT(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) \
        else $error("assertion failed");

// Clocked assertion that is checked on every edge, reset included.
`define U8D_ASSERT_ALWAYS(label, clk, prop) \
    label: assert property (@(posedge clk) (prop)) \
        else $error("assertion failed");

`endif

// ----- rtl/core/u8d_pkg.sv -----
// Package of the UTF-8 stream decoder: widths, codes and the result struct.
// No dependencies; used by every module of the block.
`timescale 1ns / 1ps

package u8d_pkg;

    localparam int COUNT_WIDTH_DEF = 16;
    localparam int BYTE_WIDTH      = 8;
    localparam int CP_WIDTH        = 21;
    localparam int LEN_WIDTH       = 3;
    localparam int PEND_WIDTH      = 2;

    localparam logic KIND_CHAR    = 1'b0;
    localparam logic KIND_SUMMARY = 1'b1;

    localparam logic [LEN_WIDTH-1:0] LEN_NONE = 3'd0;
    localparam logic [LEN_WIDTH-1:0] LEN_1    = 3'd1;
    localparam logic [LEN_WIDTH-1:0] LEN_2    = 3'd2;
    localparam logic [LEN_WIDTH-1:0] LEN_3    = 3'd3;
    localparam logic [LEN_WIDTH-1:0] LEN_4    = 3'd4;

    localparam logic [PEND_WIDTH-1:0] PEND_NONE = 2'd0;
    localparam logic [PEND_WIDTH-1:0] PEND_ONE  = 2'd1;
    localparam logic [PEND_WIDTH-1:0] PEND_TWO  = 2'd2;
    localparam logic [PEND_WIDTH-1:0] PEND_THREE = 2'd3;

    localparam logic [BYTE_WIDTH-1:0] MASK_LEAD2 = 8'hE0;
    localparam logic [BYTE_WIDTH-1:0] MASK_LEAD3 = 8'hF0;
    localparam logic [BYTE_WIDTH-1:0] MASK_LEAD4 = 8'hF8;
    localparam logic [BYTE_WIDTH-1:0] MASK_CONT  = 8'hC0;
    localparam logic [BYTE_WIDTH-1:0] TAG_LEAD2  = 8'hC0;
    localparam logic [BYTE_WIDTH-1:0] TAG_LEAD3  = 8'hE0;
    localparam logic [BYTE_WIDTH-1:0] TAG_LEAD4  = 8'hF0;
    localparam logic [BYTE_WIDTH-1:0] TAG_CONT   = 8'h80;
    localparam logic [BYTE_WIDTH-1:0] BITS_LEAD2 = 8'h1F;
    localparam logic [BYTE_WIDTH-1:0] BITS_LEAD3 = 8'h0F;
    localparam logic [BYTE_WIDTH-1:0] BITS_LEAD4 = 8'h07;
    localparam logic [BYTE_WIDTH-1:0] BITS_CONT  = 8'h3F;

    typedef struct packed {
        logic                 kind;
        logic [CP_WIDTH-1:0]  code_point;
        logic [LEN_WIDTH-1:0] char_len;
        logic                 valid_res;
    } t_char;

endpackage

// ----- rtl/core/u8d_in_reg.sv -----
// Input register of the UTF-8 stream decoder: holds one byte for the decode step.
// Depends on u8d_pkg.
`timescale 1ns / 1ps

module u8d_in_reg (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_valid,
    input  logic [u8d_pkg::BYTE_WIDTH-1:0] i_byte,
    output logic                           o_stall,
    input  logic                           i_take,
    output logic                           o_valid,
    output logic [u8d_pkg::BYTE_WIDTH-1:0] o_byte
);
    import u8d_pkg::*;

    logic                  r_valid;
    logic                  n_valid;
    logic [BYTE_WIDTH-1:0] r_byte;
    logic                  load;

    assign o_stall = r_valid && !i_take;
    assign load    = i_valid && !o_stall;

    always_comb begin
        n_valid = r_valid;
        if (load) begin
            n_valid = 1'b1;
        end else if (i_take) begin
            n_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_byte <= i_byte;
        end
    end

    assign o_valid = r_valid;
    assign o_byte  = r_byte;

endmodule

// ----- rtl/core/u8d_step.sv -----
// Decode step of the UTF-8 stream decoder: sequence state, counters and result.
// Depends on u8d_pkg.
`timescale 1ns / 1ps

module u8d_step #(
    parameter int COUNT_WIDTH = u8d_pkg::COUNT_WIDTH_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_valid,
    input  logic [u8d_pkg::BYTE_WIDTH-1:0] i_byte,
    output logic                           o_res_valid,
    output u8d_pkg::t_char                 o_char,
    output logic [COUNT_WIDTH-1:0]         o_char_count,
    output logic [COUNT_WIDTH-1:0]         o_byte_count
);
    import u8d_pkg::*;

    localparam logic [COUNT_WIDTH-1:0] CNT_MAX = '1;

    logic [PEND_WIDTH-1:0]  r_pend, n_pend;
    logic [LEN_WIDTH-1:0]   r_seq, n_seq;
    logic [CP_WIDTH-1:0]    r_acc, n_acc;
    logic [COUNT_WIDTH-1:0] r_chars, n_chars;
    logic [COUNT_WIDTH-1:0] r_bytes, n_bytes;
    logic                   r_err, n_err;

    logic [CP_WIDTH-1:0]    acc_shift;
    logic [LEN_WIDTH-1:0]   emit_len;
    logic                   emit_char;
    logic [COUNT_WIDTH:0]   byte_sum;
    logic [COUNT_WIDTH-1:0] chars_inc;
    logic [COUNT_WIDTH-1:0] bytes_inc;

    assign acc_shift = {r_acc[CP_WIDTH-7:0], i_byte[5:0]};
    assign byte_sum  = {1'b0, r_bytes} + (COUNT_WIDTH+1)'(emit_len);
    assign chars_inc = (r_chars == CNT_MAX) ? CNT_MAX : r_chars + COUNT_WIDTH'(1);
    assign bytes_inc = byte_sum[COUNT_WIDTH] ? CNT_MAX : byte_sum[COUNT_WIDTH-1:0];

    always_comb begin
        n_pend       = r_pend;
        n_seq        = r_seq;
        n_acc        = r_acc;
        n_chars      = r_chars;
        n_bytes      = r_bytes;
        n_err        = r_err;
        emit_char    = 1'b0;
        emit_len     = LEN_NONE;
        o_res_valid  = 1'b0;
        o_char       = '0;
        o_char_count = '0;
        o_byte_count = '0;

        if (r_pend != PEND_NONE) begin
            if (i_byte == '0) begin
                o_res_valid = 1'b1;
                o_char.kind = KIND_SUMMARY;
                n_pend  = PEND_NONE;
                n_seq   = LEN_NONE;
                n_acc   = '0;
                n_chars = '0;
                n_bytes = '0;
                n_err   = 1'b0;
            end else if ((i_byte & MASK_CONT) != TAG_CONT) begin
                n_err  = 1'b1;
                n_pend = PEND_NONE;
                n_seq  = LEN_NONE;
                n_acc  = '0;
            end else if (r_pend == PEND_ONE) begin
                emit_char         = 1'b1;
                emit_len          = r_seq;
                o_char.code_point = acc_shift;
                n_pend = PEND_NONE;
                n_seq  = LEN_NONE;
                n_acc  = '0;
            end else begin
                n_acc  = acc_shift;
                n_pend = r_pend - PEND_ONE;
            end
        end else if (i_byte == '0) begin
            o_res_valid = 1'b1;
            o_char.kind = KIND_SUMMARY;
            if (!r_err) begin
                o_char.valid_res = 1'b1;
                o_char_count     = r_chars;
                o_byte_count     = r_bytes;
            end
            n_pend  = PEND_NONE;
            n_seq   = LEN_NONE;
            n_acc   = '0;
            n_chars = '0;
            n_bytes = '0;
            n_err   = 1'b0;
        end else if (!r_err) begin
            if (!i_byte[BYTE_WIDTH-1]) begin
                emit_char         = 1'b1;
                emit_len          = LEN_1;
                o_char.code_point = CP_WIDTH'(i_byte);
            end else if ((i_byte & MASK_LEAD2) == TAG_LEAD2) begin
                n_acc  = CP_WIDTH'(i_byte & BITS_LEAD2);
                n_pend = PEND_ONE;
                n_seq  = LEN_2;
            end else if ((i_byte & MASK_LEAD3) == TAG_LEAD3) begin
                n_acc  = CP_WIDTH'(i_byte & BITS_LEAD3);
                n_pend = PEND_TWO;
                n_seq  = LEN_3;
            end else if ((i_byte & MASK_LEAD4) == TAG_LEAD4) begin
                n_acc  = CP_WIDTH'(i_byte & BITS_LEAD4);
                n_pend = PEND_THREE;
                n_seq  = LEN_4;
            end else begin
                n_err = 1'b1;
            end
        end

        if (emit_char) begin
            o_res_valid     = 1'b1;
            o_char.kind     = KIND_CHAR;
            o_char.char_len = emit_len;
            n_chars         = chars_inc;
            n_bytes         = bytes_inc;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend  <= PEND_NONE;
            r_seq   <= LEN_NONE;
            r_acc   <= '0;
            r_chars <= '0;
            r_bytes <= '0;
            r_err   <= 1'b0;
        end else if (i_valid) begin
            r_pend  <= n_pend;
            r_seq   <= n_seq;
            r_acc   <= n_acc;
            r_chars <= n_chars;
            r_bytes <= n_bytes;
            r_err   <= n_err;
        end
    end

endmodule

// ----- rtl/core/u8d_out_reg.sv -----
// Result register of the UTF-8 stream decoder: holds one result until its transfer.
// Depends on u8d_pkg.
`timescale 1ns / 1ps

module u8d_out_reg #(
    parameter int COUNT_WIDTH = u8d_pkg::COUNT_WIDTH_DEF
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_load,
    input  logic                   i_res_valid,
    input  u8d_pkg::t_char         i_char,
    input  logic [COUNT_WIDTH-1:0] i_char_count,
    input  logic [COUNT_WIDTH-1:0] i_byte_count,
    input  logic                   i_stall,
    output logic                   o_free,
    output logic                   o_valid,
    output u8d_pkg::t_char         o_char,
    output logic [COUNT_WIDTH-1:0] o_char_count,
    output logic [COUNT_WIDTH-1:0] o_byte_count
);
    import u8d_pkg::*;

    logic                   r_valid;
    logic                   n_valid;
    t_char                  r_char;
    logic [COUNT_WIDTH-1:0] r_char_count;
    logic [COUNT_WIDTH-1:0] r_byte_count;

    assign o_free = !r_valid || !i_stall;

    always_comb begin
        n_valid = r_valid;
        if (o_free) begin
            n_valid = i_load && i_res_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_free && i_load && i_res_valid) begin
            r_char       <= i_char;
            r_char_count <= i_char_count;
            r_byte_count <= i_byte_count;
        end
    end

    assign o_valid      = r_valid;
    assign o_char       = r_char;
    assign o_char_count = r_char_count;
    assign o_byte_count = r_byte_count;

endmodule

// ----- rtl/core/utf8_stream_decoder_top.sv -----
// Top level of the UTF-8 stream decoder: input register, decode step, result register.
// Depends on u8d_pkg, u8d_in_reg, u8d_step, u8d_out_reg and assert_macros.svh.
//
// Bytes of a zero-terminated UTF-8 string enter on the input channel (i_in_valid,
// o_in_stall, i_byte_in), one per transfer. Each completed character leaves on the
// output channel (o_out_valid, i_out_stall) with o_kind low, its code point and its
// length. A zero byte ends the string and gives a summary with o_kind high, the
// character and byte counts and o_valid_res; the counts are zero for a bad string.
// Bytes that open or continue a sequence, and bytes after an error, give no result.
// The byte that completes a result waits in the input register while the decode step
// works on it, and the result register takes the outcome once it is free to load.
// The block takes one byte every cycle while results flow out.
// When the receiver stalls, the result register holds its result; one more byte may
// wait in the input register, after which o_in_stall rises until the result leaves.
// A synchronous reset empties both registers and clears the open sequence and the counters.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module utf8_stream_decoder_top #(
    parameter int COUNT_WIDTH = u8d_pkg::COUNT_WIDTH_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_in_valid,
    output logic                           o_in_stall,
    input  logic [u8d_pkg::BYTE_WIDTH-1:0] i_byte_in,
    output logic                           o_out_valid,
    input  logic                           i_out_stall,
    output logic                           o_kind,
    output logic [u8d_pkg::CP_WIDTH-1:0]   o_code_point,
    output logic [u8d_pkg::LEN_WIDTH-1:0]  o_char_len,
    output logic [COUNT_WIDTH-1:0]         o_char_count,
    output logic [COUNT_WIDTH-1:0]         o_byte_count,
    output logic                           o_valid_res
);
    import u8d_pkg::*;

    logic                   stage_valid;
    logic [BYTE_WIDTH-1:0]  stage_byte;
    logic                   out_free;
    logic                   step_go;
    logic                   res_valid;
    t_char                  res_char;
    logic [COUNT_WIDTH-1:0] res_char_count;
    logic [COUNT_WIDTH-1:0] res_byte_count;
    t_char                  out_char;

    assign step_go = stage_valid && out_free;

    u8d_in_reg u_in_reg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_in_valid),
        .i_byte  (i_byte_in),
        .o_stall (o_in_stall),
        .i_take  (step_go),
        .o_valid (stage_valid),
        .o_byte  (stage_byte)
    );

    u8d_step #(
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_step (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (step_go),
        .i_byte       (stage_byte),
        .o_res_valid  (res_valid),
        .o_char       (res_char),
        .o_char_count (res_char_count),
        .o_byte_count (res_byte_count)
    );

    u8d_out_reg #(
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_out_reg (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_load       (step_go),
        .i_res_valid  (res_valid),
        .i_char       (res_char),
        .i_char_count (res_char_count),
        .i_byte_count (res_byte_count),
        .i_stall      (i_out_stall),
        .o_free       (out_free),
        .o_valid      (o_out_valid),
        .o_char       (out_char),
        .o_char_count (o_char_count),
        .o_byte_count (o_byte_count)
    );

    assign o_kind       = out_char.kind;
    assign o_code_point = out_char.code_point;
    assign o_char_len   = out_char.char_len;
    assign o_valid_res  = out_char.valid_res;

    `U8D_ASSERT(a_in_stall_cause, i_clk, i_rst_n, o_in_stall |-> (o_out_valid && i_out_stall))
    `U8D_ASSERT(a_char_len_legal, i_clk, i_rst_n, (o_out_valid && (o_kind == KIND_CHAR)) |-> ((o_char_len == LEN_1) || (o_char_len == LEN_2) || (o_char_len == LEN_3) || (o_char_len == LEN_4)))
    `U8D_ASSERT(a_bad_summary_zero, i_clk, i_rst_n, (o_out_valid && (o_kind == KIND_SUMMARY) && !o_valid_res) |-> ((o_char_count == '0) && (o_byte_count == '0)))

endmodule

// ----- tb/tb_utf8_stream_decoder_top.sv -----
// Self-checking testbench for utf8_stream_decoder_top: directed strings, then random
// strings, with random idling on both channels but for some random strings run without it.
// Depends on u8d_pkg and the decoder RTL; results are checked against a predictor or pinned rows.
`timescale 1ns / 1ps

module tb_utf8_stream_decoder_top;
    import u8d_pkg::*;

    localparam int CW = COUNT_WIDTH_DEF;
    localparam int CYCLE_LIMIT = 2000000;
    localparam int DRAIN_CYCLES = 20;
    localparam int RANDOM_BYTES = 630;
    localparam int MAX_PRINTED = 40;

    typedef enum int {IDLE_NORMAL, IDLE_NONE} t_idle;

    typedef struct packed {
        logic                 kind;
        logic [CP_WIDTH-1:0]  code_point;
        logic [LEN_WIDTH-1:0] char_len;
        logic [CW-1:0]        char_count;
        logic [CW-1:0]        byte_count;
        logic                 valid_res;
    } t_symbol;

    typedef struct packed {
        logic [BYTE_WIDTH-1:0] data;
        logic                  pinned;
        t_symbol               sym;
    } t_row;

    localparam t_symbol SYM_NONE    = '0;
    localparam t_symbol SYM_EMPTY   = '{KIND_SUMMARY, '0, LEN_NONE, '0, '0, 1'b1};
    localparam t_symbol SYM_INVALID = '{KIND_SUMMARY, '0, LEN_NONE, '0, '0, 1'b0};

    localparam int N_DIR = 23;
    localparam t_row DIR_ROWS [N_DIR] = '{
        '{8'h00, 1'b1, SYM_EMPTY},
        '{8'h41, 1'b1, '{KIND_CHAR, 21'h41, LEN_1, '0, '0, 1'b0}},
        '{8'h7F, 1'b1, '{KIND_CHAR, 21'h7F, LEN_1, '0, '0, 1'b0}},
        '{8'hC2, 1'b0, SYM_NONE},
        '{8'h80, 1'b0, SYM_NONE},
        '{8'hE2, 1'b0, SYM_NONE},
        '{8'h82, 1'b0, SYM_NONE},
        '{8'hAC, 1'b0, SYM_NONE},
        '{8'hF7, 1'b0, SYM_NONE},
        '{8'hBF, 1'b0, SYM_NONE},
        '{8'hBF, 1'b0, SYM_NONE},
        '{8'hBF, 1'b0, SYM_NONE},
        '{8'h00, 1'b0, SYM_NONE},
        '{8'h80, 1'b0, SYM_NONE},
        '{8'h41, 1'b0, SYM_NONE},
        '{8'h00, 1'b1, SYM_INVALID},
        '{8'hFF, 1'b0, SYM_NONE},
        '{8'h00, 1'b1, SYM_INVALID},
        '{8'hC3, 1'b0, SYM_NONE},
        '{8'h41, 1'b0, SYM_NONE},
        '{8'h00, 1'b1, SYM_INVALID},
        '{8'hE0, 1'b0, SYM_NONE},
        '{8'h00, 1'b1, SYM_INVALID}
    };

    logic                    i_clk = 1'b0;
    logic                    i_rst_n = 1'b0;
    logic                    i_in_valid = 1'b0;
    logic                    o_in_stall;
    logic [BYTE_WIDTH-1:0]   i_byte_in = '0;
    logic                    o_out_valid;
    logic                    i_out_stall = 1'b0;
    logic                    o_kind;
    logic [CP_WIDTH-1:0]     o_code_point;
    logic [LEN_WIDTH-1:0]    o_char_len;
    logic [CW-1:0]           o_char_count;
    logic [CW-1:0]           o_byte_count;
    logic                    o_valid_res;

    logic [PEND_WIDTH-1:0]   open_left = PEND_NONE;
    logic [LEN_WIDTH-1:0]    open_len = LEN_NONE;
    logic [CP_WIDTH-1:0]     cp_bits = '0;
    logic [CW-1:0]           char_total = '0;
    logic [CW-1:0]           byte_total = '0;
    logic                    str_bad = 1'b0;

    t_symbol decoded_q [$];
    t_symbol want;
    t_idle   idle_mode = IDLE_NORMAL;
    int      mismatches = 0;
    int      bytes_sent = 0;
    int      cycles = 0;
    int      stall_hold = 0;

    utf8_stream_decoder_top #(
        .COUNT_WIDTH(CW)
    ) i_dut (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .i_in_valid(i_in_valid),
        .o_in_stall(o_in_stall),
        .i_byte_in(i_byte_in),
        .o_out_valid(o_out_valid),
        .i_out_stall(i_out_stall),
        .o_kind(o_kind),
        .o_code_point(o_code_point),
        .o_char_len(o_char_len),
        .o_char_count(o_char_count),
        .o_byte_count(o_byte_count),
        .o_valid_res(o_valid_res)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    function automatic logic [CW-1:0] sat_add(input logic [CW-1:0] a, input logic [CW-1:0] b);
        logic [CW:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[CW] ? '1 : s[CW-1:0];
    endfunction

    function automatic t_symbol char_symbol(input logic [CP_WIDTH-1:0] cp,
                                            input logic [LEN_WIDTH-1:0] len);
        t_symbol s;
        char_total = sat_add(char_total, CW'(1));
        byte_total = sat_add(byte_total, CW'(len));
        s = '0;
        s.kind = KIND_CHAR;
        s.code_point = cp;
        s.char_len = len;
        return s;
    endfunction

    function automatic t_symbol summary_symbol();
        t_symbol s;
        s = '0;
        s.kind = KIND_SUMMARY;
        if (!str_bad) begin
            s.char_count = char_total;
            s.byte_count = byte_total;
            s.valid_res = 1'b1;
        end
        open_left = PEND_NONE;
        open_len = LEN_NONE;
        cp_bits = '0;
        char_total = '0;
        byte_total = '0;
        str_bad = 1'b0;
        return s;
    endfunction

    task automatic decode_byte(input logic [BYTE_WIDTH-1:0] b, output logic got,
                               output t_symbol sym);
        got = 1'b0;
        sym = '0;
        if (open_left != PEND_NONE) begin
            if (b == '0) begin
                str_bad = 1'b1;
                sym = summary_symbol();
                got = 1'b1;
            end else if ((b & MASK_CONT) != TAG_CONT) begin
                str_bad = 1'b1;
                open_left = PEND_NONE;
                open_len = LEN_NONE;
                cp_bits = '0;
            end else begin
                cp_bits = {cp_bits[CP_WIDTH-7:0], b[5:0]};
                open_left = open_left - 1'b1;
                if (open_left == PEND_NONE) begin
                    sym = char_symbol(cp_bits, open_len);
                    got = 1'b1;
                    open_len = LEN_NONE;
                    cp_bits = '0;
                end
            end
        end else if (b == '0) begin
            sym = summary_symbol();
            got = 1'b1;
        end else if (!str_bad) begin
            if (!b[7]) begin
                sym = char_symbol(CP_WIDTH'(b), LEN_1);
                got = 1'b1;
            end else if ((b & MASK_LEAD2) == TAG_LEAD2) begin
                cp_bits = CP_WIDTH'(b & BITS_LEAD2);
                open_left = PEND_ONE;
                open_len = LEN_2;
            end else if ((b & MASK_LEAD3) == TAG_LEAD3) begin
                cp_bits = CP_WIDTH'(b & BITS_LEAD3);
                open_left = PEND_TWO;
                open_len = LEN_3;
            end else if ((b & MASK_LEAD4) == TAG_LEAD4) begin
                cp_bits = CP_WIDTH'(b & BITS_LEAD4);
                open_left = PEND_THREE;
                open_len = LEN_4;
            end else begin
                str_bad = 1'b1;
            end
        end
    endtask

    function automatic int idle_len();
        int r;
        r = $urandom_range(0, 99);
        case (idle_mode)
            IDLE_NONE: return 0;
            default: begin
                if (r < 55) return 0;
                if (r < 90) return $urandom_range(1, 3);
                if (r < 97) return $urandom_range(4, 10);
                return $urandom_range(20, 40);
            end
        endcase
    endfunction

    task automatic report_mismatch(input string what);
        if (mismatches < MAX_PRINTED) $display("%0t ns: %s", $time, what);
        mismatches++;
    endtask

    task automatic send_byte(input logic [BYTE_WIDTH-1:0] data, input logic pinned,
                             input t_symbol pinned_sym);
        int gap;
        logic got;
        t_symbol sym;
        gap = idle_len();
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_byte_in <= data;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        decode_byte(data, got, sym);
        if (got) decoded_q.push_back(pinned ? pinned_sym : sym);
        bytes_sent++;
    endtask

    task automatic send_random_string();
        int n_chars;
        int c;
        int k;
        int len;
        int pick;
        logic [BYTE_WIDTH-1:0] b;
        n_chars = $urandom_range(0, 10);
        for (c = 0; c < n_chars; c++) begin
            pick = $urandom_range(0, 99);
            if (pick < 5) begin
                send_byte(BYTE_WIDTH'($urandom_range(1, 255)), 1'b0, SYM_NONE);
            end else if (pick < 8) begin
                if ($urandom_range(0, 1)) b = {2'b10, 6'($urandom_range(0, 63))};
                else b = {5'b11111, 3'($urandom_range(0, 7))};
                send_byte(b, 1'b0, SYM_NONE);
            end else begin
                len = $urandom_range(1, 4);
                case (len)
                    1: b = BYTE_WIDTH'($urandom_range(1, 127));
                    2: b = TAG_LEAD2 | BYTE_WIDTH'($urandom_range(0, 31));
                    3: b = TAG_LEAD3 | BYTE_WIDTH'($urandom_range(0, 15));
                    default: b = TAG_LEAD4 | BYTE_WIDTH'($urandom_range(0, 7));
                endcase
                send_byte(b, 1'b0, SYM_NONE);
                for (k = 1; k < len; k++) begin
                    pick = $urandom_range(0, 99);
                    if (pick < 3) begin
                        do b = BYTE_WIDTH'($urandom_range(1, 255));
                        while ((b & MASK_CONT) == TAG_CONT);
                    end else if (pick < 5) begin
                        b = '0;
                    end else begin
                        b = TAG_CONT | BYTE_WIDTH'($urandom_range(0, 63));
                    end
                    send_byte(b, 1'b0, SYM_NONE);
                    if (b == '0 || (b & MASK_CONT) != TAG_CONT) break;
                end
            end
        end
        send_byte('0, 1'b0, SYM_NONE);
    endtask

    always @(posedge i_clk) begin
        if (stall_hold > 0) begin
            stall_hold--;
        end else if (i_out_stall) begin
            i_out_stall <= 1'b0;
            stall_hold = $urandom_range(0, 8);
        end else begin
            stall_hold = idle_len();
            if (stall_hold > 0) begin
                i_out_stall <= 1'b1;
                stall_hold--;
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (decoded_q.size() == 0) begin
                report_mismatch("result transfer with nothing outstanding");
            end else begin
                want = decoded_q.pop_front();
                if (o_kind !== want.kind)
                    report_mismatch($sformatf("kind %0h, want %0h", o_kind, want.kind));
                if (o_code_point !== want.code_point)
                    report_mismatch($sformatf("code_point %0h, want %0h",
                                              o_code_point, want.code_point));
                if (o_char_len !== want.char_len)
                    report_mismatch($sformatf("char_len %0d, want %0d",
                                              o_char_len, want.char_len));
                if (o_char_count !== want.char_count)
                    report_mismatch($sformatf("char_count %0d, want %0d",
                                              o_char_count, want.char_count));
                if (o_byte_count !== want.byte_count)
                    report_mismatch($sformatf("byte_count %0d, want %0d",
                                              o_byte_count, want.byte_count));
                if (o_valid_res !== want.valid_res)
                    report_mismatch($sformatf("valid_res %0h, want %0h",
                                              o_valid_res, want.valid_res));
            end
        end
    end

    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    initial begin
        int i;
        int goal;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        for (i = 0; i < N_DIR; i++) begin
            send_byte(DIR_ROWS[i].data, DIR_ROWS[i].pinned, DIR_ROWS[i].sym);
        end

        goal = bytes_sent + RANDOM_BYTES;
        while (bytes_sent < goal) begin
            idle_mode = ($urandom_range(0, 7) == 0) ? IDLE_NONE : IDLE_NORMAL;
            send_random_string();
        end
        i_in_valid <= 1'b0;
        idle_mode = IDLE_NORMAL;

        while (decoded_q.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (mismatches == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule
